[rtl/fmv_pkg.sv]
// ----------------------------------------------------------------------------
// fmv_pkg
// shared types, constants and helpers for the two-operator fm voice
// ----------------------------------------------------------------------------
package fmv_pkg;

  // default sizes of the top level
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 24;

  // shared bit-serial multiplier
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // fixed-point constants
  localparam logic [24:0] ONE_Q24          = 25'd16777216;
  localparam logic [24:0] SUSTAIN_Q24      = 25'd9227469;
  localparam logic [24:0] DECAY_DONE_Q24   = 25'd16777;
  localparam logic [24:0] DECAY_FLOOR_Q24  = SUSTAIN_Q24 + DECAY_DONE_Q24;
  localparam logic [24:0] SILENT_Q24       = 25'd1678;
  localparam logic [24:0] SNAP_Q24         = 25'd16778;
  localparam logic [15:0] LEVEL_Q16        = 16'd58982;
  localparam logic [12:0] INDEX_SMOOTH_Q24 = 13'd4369;
  localparam logic [22:0] RETUNE_LOW       = 23'd6991;
  localparam logic [22:0] RETUNE_HIGH      = 23'd5592405;

  // sine polynomial
  localparam logic [12:0] SINE_C1  = 13'd4926;
  localparam logic [16:0] SINE_C2  = 17'd42334;
  localparam logic [16:0] SINE_C3  = 17'd102944;
  localparam logic [14:0] SINE_MAX = 15'd32767;

  // register reset values
  localparam logic [2:0]  MOD_RATIO_RST        = 3'd2;
  localparam logic [15:0] INDEX_PEAK_RST       = 16'd18350;
  localparam logic [15:0] INDEX_BODY_RST       = 16'd23593;
  localparam logic [23:0] INDEX_DECAY_COEF_RST = 24'd1165;
  localparam logic [19:0] ATTACK_STEP_RST      = 20'd19418;
  localparam logic [23:0] DECAY_COEF_RST       = 24'd1398;
  localparam logic [23:0] RELEASE_COEF_RST     = 24'd1165;
  localparam logic [23:0] GLIDE_COEF_RST       = 24'd11650;

  typedef enum logic [2:0] {
    CFG_MOD_RATIO,
    CFG_INDEX_PEAK,
    CFG_INDEX_BODY,
    CFG_INDEX_DECAY_COEF,
    CFG_ATTACK_STEP,
    CFG_DECAY_COEF,
    CFG_RELEASE_COEF,
    CFG_GLIDE_COEF
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FN_TICK,
    FN_NOTE_ON,
    FN_NOTE_OFF,
    FN_PANIC,
    FN_RETUNE
  } func_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_ATTACK,
    AS_DECAY,
    AS_SUSTAIN,
    AS_RELEASE
  } amp_stage_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ISSUE,
    SQ_WAIT,
    SQ_WB
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_GLIDE,
    OP_AMP,
    OP_IENV,
    OP_PV,
    OP_TARGET,
    OP_SMOOTH,
    OP_DTM,
    OP_SIN_X2,
    OP_SIN_T1,
    OP_SIN_T2,
    OP_SIN_Y,
    OP_OFF,
    OP_OUT_AMP,
    OP_OUT_LVL,
    OP_NOTE
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // 32768 + round(32768 * v / 255), the division by 255 done by reciprocal
  function automatic logic [16:0] vel_scale(input logic [7:0] v);
    logic [15:0] y;
    logic [15:0] q;
    y = {1'b0, v, 7'h7f};
    q = (y + (y >> 8) + 16'd1) >> 8;
    return 17'd32768 + {2'b0, v, 7'b0} + {9'b0, q[7:0]};
  endfunction

endpackage

[rtl/fmv_serial_mul.sv]
// ----------------------------------------------------------------------------
// fmv_serial_mul
// unsigned shift-add multiplier, one bit of b per cycle
// ----------------------------------------------------------------------------
module fmv_serial_mul import fmv_pkg::*; #(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output mul_stat_t          stat,
  output logic [A_W+B_W-1:0] p
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   mcand;
  logic [A_W-1:0]   hi;
  logic [B_W-1:0]   lo;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [A_W:0]     sum;

  assign sum = {1'b0, hi} + {1'b0, (lo[0] ? mcand : {A_W{1'b0}})};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (cnt != '0) begin
      hi <= sum[A_W:1];
      lo <= {sum[0], lo[B_W-1:1]};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign p         = {hi, lo};

endmodule

[rtl/two_operator_fm_voice.sv]
// ----------------------------------------------------------------------------
// two_operator_fm_voice
// one-voice two-operator phase-modulation fm synth with adsr and index env
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    func, freq_step, velocity
//  out      source     out_valid / out_stall  sample_out
//  cfg      sink       cfg_we                 cfg_index, cfg_data
//
//  a tick makes 17 or 18 passes through one shared bit-serial multiplier,
//  whose multiplier operand is 25 bits wide; a silent tick makes none
//  a note on makes one multiplier pass, other items none
//  rst is synchronous; it restores register defaults and silences the voice
//  a finished sample sits in the output register while the next item enters;
//  a tick that finishes while that register is still full waits for it
// ----------------------------------------------------------------------------
module two_operator_fm_voice import fmv_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             func,
  input  logic [22:0]            freq_step,
  input  logic [7:0]             velocity,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     sample_out,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // modulation offset shift and left alignment of the sine table index
  localparam int OFF_SH = 39 - PHASE_BITS;
  localparam int X_SH   = 18 - SINE_TABLE_BITS;

  // configuration registers
  logic [2:0]  mod_ratio;
  logic [15:0] index_peak;
  logic [15:0] index_body;
  logic [23:0] index_decay_coef;
  logic [19:0] attack_step;
  logic [23:0] decay_coef;
  logic [23:0] release_coef;
  logic [23:0] glide_coef;

  // voice state
  logic [31:0]           freq_current;
  logic [23:0]           freq_target;
  logic [PHASE_BITS-1:0] carrier_phase;
  logic [PHASE_BITS-1:0] modulator_phase;
  logic [24:0]           amp_level;
  amp_stage_t            amp_stage;
  logic [24:0]           index_envelope;
  logic [23:0]           index_current;
  logic [16:0]           velocity_scale;

  // sequencer
  seq_state_t state;
  seq_state_t state_next;
  op_t        op;
  op_t        op_after;
  logic       carrier_pass;   // second sine pass, on the modulated carrier
  logic       snap;           // note on from silence: jump pitch and index

  // working registers of one tick
  logic                  mul_neg;
  logic [PHASE_BITS-1:0] dtm;
  logic [16:0]           x2;
  logic [16:0]           tpoly;
  logic [14:0]           sin_mag;
  logic                  sin_neg;
  logic [PHASE_BITS-1:0] ph_c;
  logic signed [15:0]    result;

  // multiplier hookup
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               op_neg;
  mul_stat_t          mul_stat;
  logic [MUL_P_W-1:0] mul_p;

  logic in_accept;
  logic silent;
  logic needs_mul;
  logic wb_free;
  logic apply;

  // sine argument
  logic [PHASE_BITS-1:0]      sin_ph;
  logic [SINE_TABLE_BITS-1:0] sin_idx;
  logic [1:0]                 sin_quad;
  logic [15:0]                x_raw;
  logic [16:0]                sin_x;

  // signed differences that feed the multiplier as sign and magnitude
  logic [33:0]           glide_d;
  logic [32:0]           glide_mag;
  logic [25:0]           decay_d;
  logic [25:0]           decay_mag;
  logic [25:0]           ienv_d;
  logic [25:0]           ienv_mag;
  logic [26:0]           smooth_d;
  logic [26:0]           smooth_mag;
  logic [PHASE_BITS-1:0] dt_c;

  // envelope updates
  logic [25:0]           atk_sum;
  logic [25:0]           decay_new;
  logic [24:0]           rel_new;
  logic [PHASE_BITS-1:0] off;
  logic [16:0]           y_raw;
  logic [14:0]           out_mag;

  assign in_accept = in_valid && !in_stall;
  assign silent    = (amp_stage == AS_IDLE) && (amp_level < SILENT_Q24);
  assign wb_free   = !out_valid || !out_stall;
  assign apply     = (state == SQ_WAIT) && mul_stat.done;

  // table index from the top phase bits, folded into a quarter wave
  assign sin_ph   = carrier_pass ? ph_c : modulator_phase;
  assign sin_idx  = sin_ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign sin_quad = sin_idx[SINE_TABLE_BITS-1 -: 2];
  assign x_raw    = 16'(sin_idx[SINE_TABLE_BITS-3:0]) << X_SH;
  assign sin_x    = sin_quad[0] ? (17'h10000 - {1'b0, x_raw}) : {1'b0, x_raw};

  assign glide_d    = {2'b0, freq_target, 8'b0} - {2'b0, freq_current};
  assign glide_mag  = glide_d[33] ? 33'(-glide_d) : glide_d[32:0];
  assign decay_d    = {1'b0, SUSTAIN_Q24} - {1'b0, amp_level};
  assign decay_mag  = decay_d[25] ? -decay_d : decay_d;
  assign ienv_d     = {2'b0, index_body, 8'b0} - {1'b0, index_envelope};
  assign ienv_mag   = ienv_d[25] ? -ienv_d : ienv_d;
  // index target sits in the upper product bits until the smoothing pass
  assign smooth_d   = {1'b0, mul_p[57:32]} - {3'b0, index_current};
  assign smooth_mag = smooth_d[26] ? -smooth_d : smooth_d;
  assign dt_c       = freq_current[31 -: PHASE_BITS];

  assign atk_sum   = {1'b0, amp_level} + {6'b0, attack_step};
  assign decay_new = mul_neg ? ({1'b0, amp_level} - {1'b0, mul_p[48:24]})
                             : ({1'b0, amp_level} + {1'b0, mul_p[48:24]});
  assign rel_new   = amp_level - mul_p[48:24];
  assign off       = mul_p[OFF_SH +: PHASE_BITS];
  assign y_raw     = mul_p[33:17];
  // |c| * amp * level stays below full scale, so no clamp is needed here
  assign out_mag   = mul_p[30:16];

  // only decay and release need the multiplier for the amplitude
  assign needs_mul = !((op == OP_AMP) &&
                       (amp_stage != AS_DECAY) && (amp_stage != AS_RELEASE));

  fmv_serial_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .p     (mul_p)
  );

  // order of the multiplier passes within one tick
  always_comb begin
    op_after = op;
    unique case (op)
      OP_GLIDE:   op_after = OP_AMP;
      OP_AMP:     op_after = OP_IENV;
      OP_IENV:    op_after = OP_PV;
      OP_PV:      op_after = OP_TARGET;
      OP_TARGET:  op_after = OP_SMOOTH;
      OP_SMOOTH:  op_after = OP_DTM;
      OP_DTM:     op_after = OP_SIN_X2;
      OP_SIN_X2:  op_after = OP_SIN_T1;
      OP_SIN_T1:  op_after = OP_SIN_T2;
      OP_SIN_T2:  op_after = OP_SIN_Y;
      OP_SIN_Y:   op_after = carrier_pass ? OP_OUT_AMP : OP_OFF;
      OP_OFF:     op_after = OP_SIN_X2;
      OP_OUT_AMP: op_after = OP_OUT_LVL;
      OP_OUT_LVL: op_after = OP_OUT_LVL;
      OP_NOTE:    op_after = OP_NOTE;
      default:    op_after = op;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE: begin
        if (in_accept) begin
          if (func == FN_TICK) begin
            state_next = silent ? SQ_WB : SQ_ISSUE;
          end else if (func == FN_NOTE_ON) begin
            state_next = SQ_ISSUE;
          end
        end
      end
      SQ_ISSUE: begin
        if (needs_mul) begin
          state_next = SQ_WAIT;
        end
      end
      SQ_WAIT: begin
        if (mul_stat.done) begin
          if (op == OP_OUT_LVL) begin
            state_next = SQ_WB;
          end else if (op == OP_NOTE) begin
            state_next = SQ_IDLE;
          end else begin
            state_next = SQ_ISSUE;
          end
        end
      end
      SQ_WB: begin
        if (wb_free) begin
          state_next = SQ_IDLE;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    in_stall  = rst || (state != SQ_IDLE);
    mul_start = (state == SQ_ISSUE) && needs_mul && !mul_stat.busy;
    mul_a     = '0;
    mul_b     = '0;
    op_neg    = 1'b0;
    unique case (op)
      OP_GLIDE: begin
        mul_a  = glide_mag;
        mul_b  = MUL_B_W'(glide_coef);
        op_neg = glide_d[33];
      end
      OP_AMP: begin
        if (amp_stage == AS_DECAY) begin
          mul_a  = MUL_A_W'(decay_mag);
          mul_b  = MUL_B_W'(decay_coef);
          op_neg = decay_d[25];
        end else begin
          mul_a = MUL_A_W'(amp_level);
          mul_b = MUL_B_W'(release_coef);
        end
      end
      OP_IENV: begin
        mul_a  = MUL_A_W'(ienv_mag);
        mul_b  = MUL_B_W'(index_decay_coef);
        op_neg = ienv_d[25];
      end
      OP_PV, OP_NOTE: begin
        mul_a = MUL_A_W'(index_peak);
        mul_b = MUL_B_W'(velocity_scale);
      end
      OP_TARGET: begin
        mul_a = mul_p[32:0];
        mul_b = index_envelope;
      end
      OP_SMOOTH: begin
        mul_a  = MUL_A_W'(smooth_mag);
        mul_b  = MUL_B_W'(INDEX_SMOOTH_Q24);
        op_neg = smooth_d[26];
      end
      OP_DTM: begin
        mul_a = MUL_A_W'(dt_c);
        mul_b = MUL_B_W'(mod_ratio);
      end
      OP_SIN_X2: begin
        mul_a = MUL_A_W'(sin_x);
        mul_b = MUL_B_W'(sin_x);
      end
      OP_SIN_T1: begin
        mul_a = MUL_A_W'(x2);
        mul_b = MUL_B_W'(SINE_C1);
      end
      OP_SIN_T2: begin
        mul_a = MUL_A_W'(x2);
        mul_b = MUL_B_W'(tpoly);
      end
      OP_SIN_Y: begin
        mul_a = MUL_A_W'(sin_x);
        mul_b = MUL_B_W'(tpoly);
      end
      OP_OFF: begin
        mul_a = MUL_A_W'(index_current);
        mul_b = MUL_B_W'(sin_mag);
      end
      OP_OUT_AMP: begin
        mul_a = MUL_A_W'(amp_level);
        mul_b = MUL_B_W'(sin_mag);
      end
      OP_OUT_LVL: begin
        mul_a = MUL_A_W'(mul_p[38:24]);
        mul_b = MUL_B_W'(LEVEL_Q16);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // control, configuration and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= SQ_IDLE;
      op               <= OP_GLIDE;
      carrier_pass     <= 1'b0;
      snap             <= 1'b0;
      out_valid        <= 1'b0;
      mod_ratio        <= MOD_RATIO_RST;
      index_peak       <= INDEX_PEAK_RST;
      index_body       <= INDEX_BODY_RST;
      index_decay_coef <= INDEX_DECAY_COEF_RST;
      attack_step      <= ATTACK_STEP_RST;
      decay_coef       <= DECAY_COEF_RST;
      release_coef     <= RELEASE_COEF_RST;
      glide_coef       <= GLIDE_COEF_RST;
      freq_current     <= '0;
      freq_target      <= '0;
      carrier_phase    <= '0;
      modulator_phase  <= '0;
      amp_level        <= '0;
      amp_stage        <= AS_IDLE;
      index_envelope   <= '0;
      index_current    <= '0;
      velocity_scale   <= '0;
    end else begin
      state <= state_next;

      // register writes, masked to each register's width
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MOD_RATIO:        mod_ratio        <= cfg_data[2:0];
          CFG_INDEX_PEAK:       index_peak       <= cfg_data[15:0];
          CFG_INDEX_BODY:       index_body       <= cfg_data[15:0];
          CFG_INDEX_DECAY_COEF: index_decay_coef <= cfg_data;
          CFG_ATTACK_STEP:      attack_step      <= cfg_data[19:0];
          CFG_DECAY_COEF:       decay_coef       <= cfg_data;
          CFG_RELEASE_COEF:     release_coef     <= cfg_data;
          CFG_GLIDE_COEF:       glide_coef       <= cfg_data;
          default: ;
        endcase
      end

      // output register
      if ((state == SQ_WB) && wb_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // events that take effect at once
      if ((state == SQ_IDLE) && in_accept) begin
        unique case (func)
          FN_TICK: begin
            op           <= OP_GLIDE;
            carrier_pass <= 1'b0;
          end
          FN_NOTE_ON: begin
            op             <= OP_NOTE;
            snap           <= (amp_stage == AS_IDLE) || (amp_level < SNAP_Q24);
            velocity_scale <= vel_scale(velocity);
            freq_target    <= {1'b0, freq_step};
            index_envelope <= ONE_Q24;
            amp_stage      <= AS_ATTACK;
          end
          FN_NOTE_OFF: begin
            if (amp_stage != AS_IDLE) begin
              amp_stage <= AS_RELEASE;
            end
          end
          FN_PANIC: begin
            amp_level     <= '0;
            index_current <= '0;
            amp_stage     <= AS_IDLE;
          end
          FN_RETUNE: begin
            // pitch outside 20 Hz to 16 kHz is ignored
            if ((freq_step >= RETUNE_LOW) && (freq_step <= RETUNE_HIGH)) begin
              freq_target <= {1'b0, freq_step};
            end
          end
          default: ;
        endcase
      end

      // linear attack needs no multiplier pass
      if ((state == SQ_ISSUE) && !needs_mul) begin
        op <= op_after;
        if (amp_stage == AS_ATTACK) begin
          if (atk_sum >= {1'b0, ONE_Q24}) begin
            amp_level <= ONE_Q24;
            amp_stage <= AS_DECAY;
          end else begin
            amp_level <= atk_sum[24:0];
          end
        end
      end

      // a multiplier pass finished: fold the product into the state
      if (apply) begin
        op <= op_after;
        unique case (op)
          OP_GLIDE: begin
            freq_current <= mul_neg ? (freq_current - mul_p[55:24])
                                    : (freq_current + mul_p[55:24]);
          end
          OP_AMP: begin
            if (amp_stage == AS_DECAY) begin
              // close enough to sustain: settle there
              if (decay_new <= {1'b0, DECAY_FLOOR_Q24}) begin
                amp_level <= SUSTAIN_Q24;
                amp_stage <= AS_SUSTAIN;
              end else begin
                amp_level <= decay_new[24:0];
              end
            end else begin
              if (rel_new < SILENT_Q24) begin
                amp_level <= '0;
                amp_stage <= AS_IDLE;
              end else begin
                amp_level <= rel_new;
              end
            end
          end
          OP_IENV: begin
            index_envelope <= mul_neg ? (index_envelope - mul_p[48:24])
                                      : (index_envelope + mul_p[48:24]);
          end
          OP_SMOOTH: begin
            index_current <= mul_neg ? (index_current - mul_p[47:24])
                                     : (index_current + mul_p[47:24]);
          end
          OP_OFF: begin
            carrier_pass <= 1'b1;
          end
          OP_OUT_LVL: begin
            carrier_phase   <= carrier_phase + dt_c;
            modulator_phase <= modulator_phase + dtm;
          end
          OP_NOTE: begin
            if (snap) begin
              freq_current  <= {freq_target, 8'b0};
              index_current <= mul_p[31:8];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_neg <= op_neg;
    end
    if ((state == SQ_IDLE) && in_accept && (func == FN_TICK) && silent) begin
      result <= '0;
    end
    if ((state == SQ_WB) && wb_free) begin
      sample_out <= result;
    end
    if (apply) begin
      unique case (op)
        OP_DTM:    dtm   <= mul_p[PHASE_BITS-1:0];
        OP_SIN_X2: x2    <= mul_p[32:16];
        OP_SIN_T1: tpoly <= SINE_C2 - mul_p[32:16];
        OP_SIN_T2: tpoly <= SINE_C3 - mul_p[32:16];
        OP_SIN_Y: begin
          sin_mag <= (y_raw > {2'b0, SINE_MAX}) ? SINE_MAX : y_raw[14:0];
          sin_neg <= sin_quad[1];
        end
        OP_OFF: begin
          // carrier phase bent by the modulator, offset cut toward zero
          ph_c <= sin_neg ? (carrier_phase - off) : (carrier_phase + off);
        end
        OP_OUT_LVL: begin
          result <= sin_neg ? -$signed({1'b0, out_mag}) : $signed({1'b0, out_mag});
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/fmv_port_chk.sv]
// ----------------------------------------------------------------------------
// fmv_port_chk
// port-level checks of the fm voice, bound to the top level
// ----------------------------------------------------------------------------
module fmv_port_chk import fmv_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        func,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] sample_out
);

  // a waiting sample holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("sample changed or dropped while stalled");

  // output is clipped symmetrically
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_out != 16'sh8000)
    else $error("sample outside symmetric range");

  // ticks and note on hold the input while in work
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FN_TICK || func == FN_NOTE_ON) |=> in_stall)
    else $error("input taken while tick or note on still in work");

  // the other events finish in their own cycle
  a_quick_events: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FN_PANIC || func == FN_NOTE_OFF ||
    func == FN_RETUNE) |=> !in_stall)
    else $error("simple event held the input");

endmodule

bind two_operator_fm_voice fmv_port_chk u_port_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the two-operator fm voice: a bit-exact voice model
// predicts every tick sample, the bench drives directed and random items
// across several register settings with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
  import fmv_pkg::*;

  localparam int  LIMIT_CYCLES = 4000000;
  localparam int  SETTLE       = 600;     // longer than one tick pass
  localparam bit [63:0] PH_MASK = 64'hFFFFFF;

  // voice model and sample store
  class fm_voice_model;
    bit [31:0] mod_ratio, index_peak, index_body, index_decay_coef;
    bit [31:0] attack_step, decay_coef, release_coef, glide_coef;
    bit [31:0] freq_current, freq_target, carrier_phase, modulator_phase;
    bit [31:0] amp_level, index_envelope, index_current, velocity_scale;
    amp_stage_t stage;
    logic signed [15:0] sample_queue[$];
    int errors;

    function new();
      mod_ratio = 2; index_peak = 18350; index_body = 23593;
      index_decay_coef = 1165; attack_step = 19418; decay_coef = 1398;
      release_coef = 1165; glide_coef = 11650;
      freq_current = 0; freq_target = 0; carrier_phase = 0; modulator_phase = 0;
      amp_level = 0; index_envelope = 0; index_current = 0; velocity_scale = 0;
      stage = AS_IDLE;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t r, bit [23:0] v);
      case (r)
        CFG_MOD_RATIO:        mod_ratio = v[2:0];
        CFG_INDEX_PEAK:       index_peak = v[15:0];
        CFG_INDEX_BODY:       index_body = v[15:0];
        CFG_INDEX_DECAY_COEF: index_decay_coef = v;
        CFG_ATTACK_STEP:      attack_step = v[19:0];
        CFG_DECAY_COEF:       decay_coef = v;
        CFG_RELEASE_COEF:     release_coef = v;
        default:              glide_coef = v;
      endcase
    endfunction

    // product of a signed value and a coefficient, truncated toward zero
    function longint mul_trunc(longint d, bit [63:0] c, int sh);
      bit [63:0] mag;
      mag = (d < 0) ? -d : d;
      mag = (mag * c) >> sh;
      return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function longint sine_q15(bit [63:0] phase);
      bit [31:0] u;
      bit [63:0] x, x2, t1, t2, y;
      u = 32'(((phase & PH_MASK) >> 14) << 22);
      x = (u >> 14) & 64'hFFFF;
      if (u[30]) x = 65536 - x;
      x2 = (x * x) >> 16;
      t1 = 42334 - ((4926 * x2) >> 16);
      t2 = 102944 - ((x2 * t1) >> 16);
      y = ((x * t2) >> 16) >> 1;
      if (y > 32767) y = 32767;
      return u[31] ? -longint'(y) : longint'(y);
    endfunction

    function longint render();
      longint d, m, c, off, res;
      bit [63:0] tgt, dt_c, dt_m, ph;
      // pitch glide
      d = longint'({32'b0, freq_target} << 8) - longint'({32'b0, freq_current});
      freq_current = 32'(longint'({32'b0, freq_current}) + mul_trunc(d, glide_coef, 24));
      // amplitude envelope
      case (stage)
        AS_ATTACK: begin
          amp_level = amp_level + attack_step;
          if (amp_level >= 32'd16777216) begin
            amp_level = 32'd16777216;
            stage = AS_DECAY;
          end
        end
        AS_DECAY: begin
          d = longint'(9227469) - longint'({32'b0, amp_level});
          amp_level = 32'(longint'({32'b0, amp_level}) + mul_trunc(d, decay_coef, 24));
          if (amp_level <= 32'd9227469 + 32'd16777) begin
            amp_level = 32'd9227469;
            stage = AS_SUSTAIN;
          end
        end
        AS_RELEASE: begin
          amp_level = amp_level - 32'(({32'b0, amp_level} * release_coef) >> 24);
          if (amp_level < 32'd1678) begin
            amp_level = 0;
            stage = AS_IDLE;
          end
        end
        default: ;
      endcase
      // index envelope and smoothing
      d = longint'({32'b0, index_body} << 8) - longint'({32'b0, index_envelope});
      index_envelope = 32'(longint'({32'b0, index_envelope}) +
                           mul_trunc(d, index_decay_coef, 24));
      tgt = ({32'b0, index_peak} * velocity_scale * index_envelope) >> 32;
      d = longint'(tgt) - longint'({32'b0, index_current});
      index_current = 32'(longint'({32'b0, index_current}) + mul_trunc(d, 4369, 24))
                      & 32'hFFFFFF;
      // operators
      dt_c = {32'b0, freq_current} >> 8;
      dt_m = dt_c * mod_ratio;
      m = sine_q15({32'b0, modulator_phase});
      off = mul_trunc(m, index_current, 15);
      ph = ({32'b0, carrier_phase} + 64'(off)) & PH_MASK;
      c = sine_q15(ph);
      carrier_phase = 32'(({32'b0, carrier_phase} + dt_c) & PH_MASK);
      modulator_phase = 32'(({32'b0, modulator_phase} + dt_m) & PH_MASK);
      res = mul_trunc(c, amp_level, 24);
      res = mul_trunc(res, 58982, 16);
      if (res > 32767) res = 32767;
      if (res < -32767) res = -32767;
      return res;
    endfunction

    // apply one accepted item, queue its sample if it makes one
    function void note_item(bit [2:0] f, bit [22:0] step, bit [7:0] vel);
      longint s;
      case (f)
        FN_TICK: begin
          if (stage == AS_IDLE && amp_level < 32'd1678) s = 0;
          else s = render();
          sample_queue.push_back(16'(s));
        end
        FN_NOTE_ON: begin
          velocity_scale = 32768 + (32768 * 32'(vel) + 127) / 255;
          if (stage == AS_IDLE || amp_level < 32'd16778) begin
            freq_current = {1'b0, step, 8'b0};
            index_current = 32'(({32'b0, index_peak} * velocity_scale) >> 8)
                            & 32'hFFFFFF;
          end
          freq_target = step;
          index_envelope = 32'd16777216;
          stage = AS_ATTACK;
        end
        FN_NOTE_OFF: if (stage != AS_IDLE) stage = AS_RELEASE;
        FN_PANIC: begin
          amp_level = 0;
          index_current = 0;
          stage = AS_IDLE;
        end
        FN_RETUNE: if (step >= 23'd6991 && step <= 23'd5592405) freq_target = step;
        default: ;
      endcase
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (sample_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample %0d", got);
        return;
      end
      want = sample_queue.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("sample mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return sample_queue.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [22:0] freq_step = '0;
  logic [7:0] velocity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fm_voice_model voice = new();
  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  logic hold_off = 1'b0;   // long receiver hold-off
  int cycles = 0;

  two_operator_fm_voice u_top (
    .clk, .rst, .in_valid, .in_stall, .func, .freq_step, .velocity,
    .out_valid, .out_stall, .sample_out, .cfg_we, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check each accepted sample, then choose the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) voice.check_sample(sample_out);
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // offer one item, hold it until taken; valid stays high into the next item
  // unless the sender decides to idle
  task automatic send_item(bit [2:0] f, bit [22:0] step, bit [7:0] vel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    freq_step <= step;
    velocity <= vel;
    do @(posedge clk); while (in_stall);
    voice.note_item(f, step, vel);
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(FN_TICK, 23'($urandom), 8'($urandom));
  endtask

  // wait for every sample, then let a possible note on finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (voice.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, bit [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    voice.set_reg(r, v);
    @(posedge clk);
  endtask

  // one register set; fast sets keep envelopes short so release completes
  task automatic load_regs(int kind);
    cfg_reg_t r;
    for (int i = 0; i < 8; i++) begin
      r = cfg_reg_t'(i);
      case (kind)
        0: write_reg(r, 24'hFFFFFF);                          // all ones
        1: write_reg(r, (r == CFG_MOD_RATIO) ? 24'd1 : 24'd0); // zeros, holds
        2: case (r)
             CFG_MOD_RATIO:  write_reg(r, 24'($urandom_range(1, 6)));
             CFG_INDEX_PEAK: write_reg(r, 24'($urandom_range(3277, 58982)));
             CFG_INDEX_BODY: write_reg(r, 24'($urandom_range(0, 52429)));
             CFG_ATTACK_STEP: write_reg(r, 24'($urandom_range(200000, 1048575)));
             default:        write_reg(r, 24'($urandom_range(300000, 16777215)));
           endcase
        default: write_reg(r, 24'($urandom));
      endcase
    end
  endtask

  // mostly complete notes with random content, some raw items mixed in
  task automatic random_items(int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 75) begin
        send_item(FN_NOTE_ON, 23'($urandom), 8'($urandom));
        ticks($urandom_range(1, 12));
        if ($urandom_range(3) == 0) begin
          send_item(FN_RETUNE, 23'($urandom_range(6000, 5600000)), 8'($urandom));
          sent++;
        end
        ticks($urandom_range(1, 8));
        if ($urandom_range(4) == 0) send_item(FN_NOTE_ON, 23'($urandom), 8'($urandom));
        send_item(FN_NOTE_OFF, 23'($urandom), 8'($urandom));
        ticks($urandom_range(1, 20));
        if ($urandom_range(5) == 0) send_item(FN_PANIC, 23'($urandom), 8'($urandom));
        sent += 20;
      end else begin
        send_item(3'($urandom), 23'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle behavior, retune limits, note extremes, unknown codes
    send_item(FN_TICK, 23'h7FFFFF, 8'hFF);
    send_item(FN_NOTE_OFF, 23'd0, 8'd0);
    send_item(FN_PANIC, 23'd0, 8'd0);
    send_item(FN_RETUNE, 23'd6990, 8'd0);
    send_item(FN_RETUNE, 23'd5592406, 8'd0);
    send_item(FN_NOTE_ON, 23'd0, 8'd0);
    ticks(2);
    send_item(FN_RETUNE, 23'd6991, 8'd0);
    ticks(1);
    send_item(FN_RETUNE, 23'd5592405, 8'd0);
    ticks(1);
    send_item(FN_NOTE_ON, 23'h7FFFFF, 8'hFF);   // no snap while sounding
    ticks(2);
    send_item(3'd5, 23'h7FFFFF, 8'hFF);
    send_item(3'd6, 23'd0, 8'd0);
    send_item(3'd7, 23'h555555, 8'hAA);
    send_item(FN_NOTE_OFF, 23'd0, 8'd0);
    ticks(2);
    send_item(FN_PANIC, 23'd0, 8'd0);
    send_item(FN_NOTE_ON, 23'h2AAAAA, 8'h55);   // snaps after panic
    ticks(2);
    drain();

    // defaults, no idling, with a long receiver hold-off to back up the block
    fork
      begin
        hold_off <= 1'b1;
        repeat (4000) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    random_items(150);
    drain();

    load_regs(2);
    send_idle_pct = 82;
    random_items(200);
    drain();

    load_regs(0);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    random_items(150);
    drain();

    load_regs(1);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    random_items(120);
    drain();

    load_regs(2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items(200);
    drain();

    load_regs(3);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    random_items(200);
    drain();

    if (voice.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
